/* hdl/iau_pkg.sv */
package iau_pkg;

    // pipeline depth, one register stage each
    localparam int STAGES = 8;

    // activation modes
    localparam logic [2:0] MODE_SIGMOID = 3'd0;
    localparam logic [2:0] MODE_TANH    = 3'd1;
    localparam logic [2:0] MODE_RESCALE = 3'd2;
    localparam logic [2:0] MODE_RELU    = 3'd3;
    localparam logic [2:0] MODE_LEAKY   = 3'd4;
    localparam logic [2:0] MODE_PASS    = 3'd5;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_SHIFT = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    localparam logic signed [31:0] OUT_LIMIT = 32'sd127;
    localparam logic signed [31:0] RELU_TOP  = 32'sd127;
    localparam logic signed [31:0] LEAKY_TOP = 32'sd32767;
    localparam logic [30:0]        FLAT_CODE = 31'h7FFF_FFFF;
    localparam logic [30:0]        GRAD_ONE  = 31'd1;
    localparam logic [30:0]        GRAD_LEAK = 31'd5;

    // ceil(2^18 / 5): exact x/5 for x below 2^15
    localparam logic [15:0] LEAK_RECIP = 16'd52429;
    localparam int          LEAK_SHIFT = 18;

    // curve joints and slope codes
    localparam logic signed [9:0] JOINT_TAB [6] = '{
        -10'sd127, -10'sd74, -10'sd31, 10'sd32, 10'sd75, 10'sd128
    };
    localparam logic [30:0] GRAD_TAB [7] = '{
        OUT_LIMIT[30:0], 31'd8, 31'd2, 31'd1, 31'd2, 31'd8, OUT_LIMIT[30:0]
    };

    // curve offsets
    localparam logic signed [31:0] SIG_OFS1 = 32'sd20;
    localparam logic signed [31:0] SIG_OFS2 = 32'sd48;
    localparam logic signed [31:0] SIG_OFS3 = 32'sd64;
    localparam logic signed [31:0] SIG_OFS4 = 32'sd80;
    localparam logic signed [31:0] SIG_OFS5 = 32'sd108;
    localparam logic signed [31:0] TANH_OFS_OUT = 32'sd88;
    localparam logic signed [31:0] TANH_OFS_IN  = 32'sd32;

    // one pipeline slot; each stage fills its own fields
    typedef struct packed {
        logic signed [31:0] v;     // input element
        logic [31:0]        mag;   // |v|
        logic [31:0]        a;     // |v| >> k
        logic [12:0]        leak;  // |v| / 5, low range only
        logic               sat;   // quotient beyond 255
        logic [23:0]        rem;   // divider remainder
        logic [7:0]         quo;   // divider quotient
        logic signed [31:0] y;     // result value
        logic [30:0]        g;     // result slope code
    } t_slot;

endpackage

/* hdl/integer_activation_unit_core.sv */
// Integer activation unit: sigmoid, tanh, rescale, relu, leaky relu, pass-through.
// Throughput: one beat per cycle while the output is not stalled; the divider
// (used in tanh and sigmoid) is four stages of two restoring steps each, so it
// never holds a beat back.
// Reset (i_rst_n low, synchronous): pipeline emptied, mode 0, shift 0, count 1.
module integer_activation_unit_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_in_value,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_act_value,
    output logic [30:0]        o_grad_inverse,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // ------------------------------------------------------------------
    // Configuration registers. The user writes them only while the pipe is empty
    // (the block does not enforce it), so every stage reads them directly.
    // ------------------------------------------------------------------
    logic [2:0]  r_mode;
    logic [4:0]  r_shift;
    logic [15:0] r_count;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= iau_pkg::MODE_SIGMOID;
            r_shift <= 5'd0;
            r_count <= 16'd1;
        end else if (w_wr) begin
            case (paddr[3:2])
                iau_pkg::REG_MODE:  r_mode  <= pwdata[2:0];
                iau_pkg::REG_SHIFT: r_shift <= pwdata[4:0];
                iau_pkg::REG_COUNT: r_count <= pwdata[15:0];
                default: ;  // no register there, write dropped
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            iau_pkg::REG_MODE:  prdata = {29'd0, r_mode};
            iau_pkg::REG_SHIFT: prdata = {27'd0, r_shift};
            iau_pkg::REG_COUNT: prdata = {16'd0, r_count};
            default:            prdata = 32'd0;
        endcase
    end

    // Divisor after the 2^k shift: item count in tanh (zero taken as one),
    // one in every other mode, so in sigmoid the same divider just saturates the shifted value.
    logic [15:0] w_cnt;
    assign w_cnt = (r_mode != iau_pkg::MODE_TANH) ? 16'd1 :
                   (r_count == 16'd0)             ? 16'd1 : r_count;

    // ------------------------------------------------------------------
    // Pipeline control. A stage loads when it is empty or the stage after
    // it moves, so bubbles close up behind a stalled output beat.
    // ------------------------------------------------------------------
    logic [iau_pkg::STAGES-1:0] r_vld;
    logic [iau_pkg::STAGES-1:0] w_en;
    iau_pkg::t_slot             r_st [iau_pkg::STAGES];
    iau_pkg::t_slot             n_st [iau_pkg::STAGES];

    always_comb begin
        w_en[iau_pkg::STAGES-1] = !r_vld[iau_pkg::STAGES-1] || !i_stall;
        for (int i = iau_pkg::STAGES - 2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign o_stall = !w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < iau_pkg::STAGES; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < iau_pkg::STAGES; i++) begin
            if (w_en[i]) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final-stage curve helpers
    // ------------------------------------------------------------------
    // signed divide by 2^sh, truncating toward zero
    function automatic logic signed [9:0] sdiv_pow2(input logic signed [9:0] x,
                                                    input logic [1:0] sh);
        logic signed [9:0] bias;
        bias = x[9] ? $signed((10'd1 << sh) - 10'd1) : 10'sd0;
        return (x + bias) >>> sh;
    endfunction

    logic [7:0]         w_q;
    logic signed [9:0]  w_x;
    logic [2:0]         w_seg;
    logic signed [31:0] w_y;
    logic [30:0]        w_g;
    logic [30:0]        w_lprod;

    always_comb begin
        w_q = r_st[6].sat ? 8'hFF : r_st[6].quo;
        w_x = r_st[6].v[31] ? -$signed({2'b00, w_q}) : $signed({2'b00, w_q});
        w_seg = 3'd0;
        for (int i = 0; i < 6; i++) begin
            if (w_x >= iau_pkg::JOINT_TAB[i]) begin
                w_seg = w_seg + 3'd1;
            end
        end

        case (r_mode)
            iau_pkg::MODE_SIGMOID: begin
                w_g = iau_pkg::GRAD_TAB[w_seg];
                case (w_seg)
                    3'd0:    w_y = 32'sd1;
                    3'd1:    w_y = 32'(sdiv_pow2(w_x, 2'd3)) + iau_pkg::SIG_OFS1;
                    3'd2:    w_y = 32'(sdiv_pow2(w_x, 2'd1)) + iau_pkg::SIG_OFS2;
                    3'd3:    w_y = 32'(w_x) + iau_pkg::SIG_OFS3;
                    3'd4:    w_y = 32'(sdiv_pow2(w_x, 2'd1)) + iau_pkg::SIG_OFS4;
                    3'd5:    w_y = 32'(sdiv_pow2(w_x, 2'd3)) + iau_pkg::SIG_OFS5;
                    default: w_y = iau_pkg::OUT_LIMIT;
                endcase
            end
            iau_pkg::MODE_TANH: begin
                w_g = iau_pkg::GRAD_TAB[w_seg];
                case (w_seg)
                    3'd0:    w_y = -iau_pkg::OUT_LIMIT;
                    3'd1:    w_y = 32'(sdiv_pow2(w_x, 2'd2)) - iau_pkg::TANH_OFS_OUT;
                    3'd2:    w_y = 32'(w_x) - iau_pkg::TANH_OFS_IN;
                    3'd3:    w_y = 32'(w_x) <<< 1;
                    3'd4:    w_y = 32'(w_x) + iau_pkg::TANH_OFS_IN;
                    3'd5:    w_y = 32'(sdiv_pow2(w_x, 2'd2)) + iau_pkg::TANH_OFS_OUT;
                    default: w_y = iau_pkg::OUT_LIMIT;
                endcase
            end
            iau_pkg::MODE_RESCALE: begin
                w_g = iau_pkg::GRAD_ONE;
                w_y = r_st[6].v[31] ? -$signed(r_st[6].a) : $signed(r_st[6].a);
            end
            iau_pkg::MODE_RELU: begin
                if (r_st[6].v < 32'sd0) begin
                    w_y = 32'sd0;
                    w_g = iau_pkg::FLAT_CODE;
                end else if (r_st[6].v > iau_pkg::RELU_TOP) begin
                    w_y = iau_pkg::RELU_TOP;
                    w_g = iau_pkg::FLAT_CODE;
                end else begin
                    w_y = r_st[6].v;
                    w_g = iau_pkg::GRAD_ONE;
                end
            end
            iau_pkg::MODE_LEAKY: begin
                if (r_st[6].v < -iau_pkg::LEAKY_TOP) begin
                    w_y = -iau_pkg::LEAKY_TOP;
                    w_g = iau_pkg::FLAT_CODE;
                end else if (r_st[6].v < 32'sd0) begin
                    w_y = -$signed({19'd0, r_st[6].leak});
                    w_g = iau_pkg::GRAD_LEAK;
                end else if (r_st[6].v < iau_pkg::LEAKY_TOP) begin
                    w_y = r_st[6].v;
                    w_g = iau_pkg::GRAD_ONE;
                end else begin
                    w_y = iau_pkg::LEAKY_TOP;
                    w_g = iau_pkg::FLAT_CODE;
                end
            end
            default: begin
                // pass-through, and the unused mode codes
                w_y = r_st[6].v;
                w_g = iau_pkg::GRAD_ONE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stage logic
    //   0: capture, magnitude
    //   1: 2^k shift, leaky /5 by reciprocal multiply
    //   2: saturation check against count * 256, divider setup
    //   3-6: restoring divide, two quotient bits a stage
    //   7: curve / clamp, result register
    // ------------------------------------------------------------------
    assign w_lprod = 31'(r_st[0].mag[14:0]) * 31'(iau_pkg::LEAK_RECIP);

    always_comb begin
        int          b;
        logic [23:0] d;

        n_st[0]     = r_st[0];
        n_st[0].v   = i_in_value;
        n_st[0].mag = i_in_value[31] ? (~$unsigned(i_in_value) + 32'd1)
                                     : $unsigned(i_in_value);

        n_st[1]      = r_st[0];
        n_st[1].a    = r_st[0].mag >> r_shift;
        n_st[1].leak = w_lprod[30:iau_pkg::LEAK_SHIFT];

        n_st[2]     = r_st[1];
        n_st[2].sat = (r_st[1].a[31:8] >= 24'(w_cnt));
        n_st[2].rem = r_st[1].a[23:0];
        n_st[2].quo = 8'd0;

        for (int j = 3; j <= 6; j++) begin
            n_st[j] = r_st[j-1];
            for (int t = 0; t < 2; t++) begin
                b = 7 - 2 * (j - 3) - t;
                d = 24'(w_cnt) << b;
                if (n_st[j].rem >= d) begin
                    n_st[j].rem    = n_st[j].rem - d;
                    n_st[j].quo[b] = 1'b1;
                end
            end
        end

        n_st[7]   = r_st[6];
        n_st[7].y = w_y;
        n_st[7].g = w_g;
    end

    assign o_valid        = r_vld[iau_pkg::STAGES-1];
    assign o_act_value    = r_st[iau_pkg::STAGES-1].y;
    assign o_grad_inverse = r_st[iau_pkg::STAGES-1].g;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // upstream only sees stall when every slot is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled with a free pipeline slot");

    // slope code is one of the defined values
    a_grad_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_grad_inverse == 31'd1 || o_grad_inverse == 31'd2 ||
                     o_grad_inverse == 31'd5 || o_grad_inverse == 31'd8 ||
                     o_grad_inverse == iau_pkg::OUT_LIMIT[30:0] ||
                     o_grad_inverse == iau_pkg::FLAT_CODE))
        else $error("undefined slope code");

    // leaky slope only comes from the negative region
    a_leak_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_grad_inverse == iau_pkg::GRAD_LEAK) |->
            (o_act_value[31] || o_act_value == 32'sd0))
        else $error("leaky slope with positive value");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    // Spare mode codes (decode as pass-through) and the unused register slot
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;
    localparam logic [1:0] REG_NONE     = 2'd3;

    localparam longint      CURVE_LIMIT = 127;          // curve saturation / end-segment slope code
    localparam logic [30:0] GRAD_FLAT   = 31'h7FFF_FFFF;
    localparam logic [30:0] GRAD_UNIT   = 31'd1;
    localparam longint      ELEM_MIN    = -64'sd2147483648;
    localparam longint      ELEM_MAX    = 64'sd2147483647;

    localparam int RAND_PHASES   = 24;
    localparam int PHASE_BEATS   = 56;
    localparam int LONG_HOLD     = 200;   // cycles of forced output stall
    localparam int SETTLE_CYCLES = 32;    // settle time after the final drain

    typedef struct {
        logic signed [31:0] act;
        logic [30:0]        grad;
    } t_act_beat;

    // DUT ports; the inputs are all known from time zero
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_in_value     = '0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    logic signed [31:0] o_act_value;
    logic [30:0]        o_grad_inverse;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [3:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow of the configuration registers, updated as each write lands
    logic [2:0]  cfg_mode  = iau_pkg::MODE_SIGMOID;
    logic [4:0]  cfg_shift = 5'd0;
    logic [15:0] cfg_count = 16'd1;

    logic signed [31:0] pending_elems [$];   // elements not yet offered
    t_act_beat          expected_acts [$];   // predicted results, oldest first

    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int mismatches     = 0;
    int beats_in       = 0;
    int beats_out      = 0;
    int settings_used  = 1;

    integer_activation_unit_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_value     (i_in_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_act_value    (o_act_value),
        .o_grad_inverse (o_grad_inverse),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Expected activation for one element under the current register shadow.
    // All arithmetic in 64 bits; SV division truncates toward zero.
    function automatic t_act_beat activate(input logic signed [31:0] elem);
        t_act_beat   beat;
        longint      v;
        longint      divisor;
        longint      x;
        longint      y;
        logic [30:0] g;
        int          seg;
        v       = elem;
        divisor = longint'(1) << cfg_shift;   // 2^31 fits, no overflow
        y       = v;
        g       = GRAD_UNIT;
        case (cfg_mode)
            iau_pkg::MODE_SIGMOID, iau_pkg::MODE_TANH: begin
                // tanh folds in the item count; a zero count acts as one
                if (cfg_mode == iau_pkg::MODE_TANH && cfg_count != 16'd0)
                    divisor = divisor * longint'(cfg_count);
                x = v / divisor;
                if (x < -127)      seg = 0;
                else if (x < -74)  seg = 1;
                else if (x < -31)  seg = 2;
                else if (x < 32)   seg = 3;
                else if (x < 75)   seg = 4;
                else if (x < 128)  seg = 5;
                else               seg = 6;
                case (seg)
                    0, 6:    g = CURVE_LIMIT[30:0];
                    1, 5:    g = 31'd8;
                    2, 4:    g = 31'd2;
                    default: g = GRAD_UNIT;
                endcase
                if (cfg_mode == iau_pkg::MODE_SIGMOID) begin
                    case (seg)
                        0:       y = 1;
                        1:       y = x / 8 + 20;
                        2:       y = x / 2 + 48;
                        3:       y = x + 64;
                        4:       y = x / 2 + 80;
                        5:       y = x / 8 + 108;
                        default: y = CURVE_LIMIT;
                    endcase
                end else begin
                    case (seg)
                        0:       y = -CURVE_LIMIT;
                        1:       y = x / 4 - 88;
                        2:       y = x - 32;
                        3:       y = 2 * x;
                        4:       y = x + 32;
                        5:       y = x / 4 + 88;
                        default: y = CURVE_LIMIT;
                    endcase
                end
            end
            iau_pkg::MODE_RESCALE: begin
                y = v / divisor;
            end
            iau_pkg::MODE_RELU: begin
                if (v < 0) begin
                    y = 0;
                    g = GRAD_FLAT;
                end else if (v > 127) begin
                    y = 127;
                    g = GRAD_FLAT;
                end
            end
            iau_pkg::MODE_LEAKY: begin
                if (v < -32767) begin
                    y = -32767;
                    g = GRAD_FLAT;
                end else if (v < 0) begin
                    y = v / 5;
                    g = 31'd5;
                end else if (v >= 32767) begin
                    y = 32767;
                    g = GRAD_FLAT;
                end
            end
            default: ;   // pass-through, spare codes included
        endcase
        beat.act  = y[31:0];
        beat.grad = g;
        return beat;
    endfunction

    // Random element shaped for the current mode: mostly values that land on
    // the interesting joints, the rest full-range noise.
    function automatic logic signed [31:0] pick_element();
        longint divisor;
        longint rem;
        longint val;
        int     roll;
        roll    = $urandom_range(99);
        divisor = longint'(1) << cfg_shift;
        if (cfg_mode == iau_pkg::MODE_TANH && cfg_count != 16'd0)
            divisor = divisor * longint'(cfg_count);
        if (roll < 20)
            return $urandom;
        case (cfg_mode)
            iau_pkg::MODE_SIGMOID, iau_pkg::MODE_TANH: begin
                // pick a curve point, then blow it back up by the divisor
                rem = longint'($urandom) % divisor;
                val = (longint'($urandom_range(400)) - 200) * divisor;
                val = $urandom_range(1) ? val + rem : val - rem;
            end
            iau_pkg::MODE_RELU: val = longint'($urandom_range(400)) - 200;
            iau_pkg::MODE_LEAKY: begin
                if (roll < 40)
                    val = longint'($urandom_range(32768, 32766));
                else
                    val = longint'($urandom_range(80000)) - 40000;
                if ($urandom_range(1))
                    val = -val;
            end
            default: val = $signed($urandom) >>> $urandom_range(31);
        endcase
        if (val > ELEM_MAX || val < ELEM_MIN)
            val = $signed($urandom);
        return val[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one beat held until accepted; the next one is offered
    // (or the line idles) only once the current beat is gone.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_acts.push_back(activate(i_in_value));
                beats_in++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_elems.size() > 0 &&
                    (send_idle_pct == 0 || $urandom_range(99) >= send_idle_pct)) begin
                    i_valid    <= 1'b1;
                    i_in_value <= pending_elems.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output stall: random back-pressure, plus long holds on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Result monitor: every accepted beat against the oldest prediction
    always @(posedge i_clk) begin
        t_act_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_out++;
            if (expected_acts.size() == 0) begin
                $display("%0t: unexpected result beat act=%0d grad=%0d",
                         $time, o_act_value, o_grad_inverse);
                mismatches++;
            end else begin
                want = expected_acts.pop_front();
                if (o_act_value !== want.act) begin
                    $display("%0t: act_value mismatch: expected %0d, got %0d",
                             $time, want.act, o_act_value);
                    mismatches++;
                end
                if (o_grad_inverse !== want.grad) begin
                    $display("%0t: grad_inverse mismatch: expected %0d, got %0d",
                             $time, want.grad, o_grad_inverse);
                    mismatches++;
                end
            end
        end
    end

    // Wait for the sender to run dry and every predicted result to arrive;
    // sampled mid-cycle so the edge's driver and monitor updates have settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_elems.size() != 0 || i_valid || expected_acts.size() != 0);
    endtask

    // APB write with setup and access phases; the register lands on the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            iau_pkg::REG_MODE:  cfg_mode  = value[2:0];
            iau_pkg::REG_SHIFT: cfg_shift = value[4:0];
            iau_pkg::REG_COUNT: cfg_count = value[15:0];
            default: ;   // unmapped slot: no effect
        endcase
    endtask

    // New register setting, only once the pipe is empty
    task automatic apply_config(input logic [2:0] mode, input logic [4:0] shift,
                                input logic [15:0] count);
        wait_drained();
        write_reg(iau_pkg::REG_MODE, 32'(mode));
        write_reg(iau_pkg::REG_SHIFT, 32'(shift));
        write_reg(iau_pkg::REG_COUNT, 32'(count));
        settings_used++;
    endtask

    // Idle patterns: none, sender mostly idle, receiver mostly stalled, light both
    task automatic set_idling(input int pattern);
        case (pattern)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 87; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 87; end
            default: begin send_idle_pct = 6;  stall_pct = 6;  end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [4:0]  shift;
        logic [15:0] count;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset setting is sigmoid with no scaling; hit every joint
        // plus both ends of the input range.
        set_idling(0);
        pending_elems.push_back(32'sh8000_0000);
        pending_elems.push_back(-32'sd127);
        pending_elems.push_back(-32'sd74);
        pending_elems.push_back(-32'sd31);
        pending_elems.push_back(32'sd32);
        pending_elems.push_back(32'sd75);
        pending_elems.push_back(32'sd128);
        pending_elems.push_back(32'sh7FFF_FFFF);

        // tanh with the widest shift and a zero item count
        apply_config(iau_pkg::MODE_TANH, 5'd31, 16'd0);
        pending_elems.push_back(32'sh8000_0000);
        pending_elems.push_back(32'sh7FFF_FFFF);

        // rescale by 2^31
        apply_config(iau_pkg::MODE_RESCALE, 5'd31, 16'd1);
        pending_elems.push_back(32'sh8000_0000);
        pending_elems.push_back(32'sh7FFF_FFFF);

        // relu clamp edges
        apply_config(iau_pkg::MODE_RELU, 5'd0, 16'd1);
        pending_elems.push_back(-32'sd1);
        pending_elems.push_back(32'sd0);
        pending_elems.push_back(32'sd127);
        pending_elems.push_back(32'sd128);

        // leaky relu: clamp edges and the divide-by-five region
        apply_config(iau_pkg::MODE_LEAKY, 5'd0, 16'd1);
        pending_elems.push_back(-32'sd32768);
        pending_elems.push_back(-32'sd32767);
        pending_elems.push_back(-32'sd1);
        pending_elems.push_back(32'sd32766);
        pending_elems.push_back(32'sd32767);

        // pass-through; a write to the unmapped slot must not disturb the mode
        apply_config(iau_pkg::MODE_PASS, 5'd7, 16'd3);
        pending_elems.push_back(32'sh8000_0000);
        wait_drained();
        write_reg(REG_NONE, 32'(iau_pkg::MODE_SIGMOID));
        pending_elems.push_back(32'sh7FFF_FFFF);

        // spare mode codes fall back to pass-through
        apply_config(MODE_SPARE_A, 5'd3, 16'd9);
        pending_elems.push_back(-32'sd5);
        apply_config(MODE_SPARE_B, 5'd3, 16'd9);
        pending_elems.push_back(-32'sd5);

        // Random phases: walk all eight mode codes against shift 0, small
        // shifts, 30 and 31, and counts of 65535, 0 and small values.
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p % 3)
                0:       shift = 5'd0;
                1:       shift = 5'($urandom_range(12, 1));
                default: shift = (p % 2) ? 5'd31 : 5'd30;
            endcase
            case (p / 8)
                0:       count = 16'hFFFF;
                1:       count = 16'd0;
                default: count = 16'($urandom_range(300, 1));
            endcase
            apply_config(3'(p % 8), shift, count);
            set_idling((p + p / 8) % 4);
            if (p % 12 == 0) begin
                // back-pressure burst: sender keeps offering while the
                // output is held, so the pipe fills and stalls the input;
                // then the sender waits for a full drain before going on
                set_idling(0);
                for (int n = 0; n < PHASE_BEATS / 2; n++)
                    pending_elems.push_back(pick_element());
                hold_requests++;
                wait_drained();
                for (int n = PHASE_BEATS / 2; n < PHASE_BEATS; n++)
                    pending_elems.push_back(pick_element());
            end else begin
                for (int n = 0; n < PHASE_BEATS; n++)
                    pending_elems.push_back(pick_element());
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d elements in, %0d results checked, %0d register settings",
                 beats_in, beats_out, settings_used);
        $display("tb_top: all mode codes, shifts 0..31, counts 0..65535, stall/idle mixes");
        if (mismatches == 0 && expected_acts.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/iau_pkg.sv
hdl/integer_activation_unit_core.sv
sim/tb_top.sv
